[sv/ebrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrs_pkg
// shared types and constants for the event bucket reservoir sampler
// ----------------------------------------------------------------------------
package ebrs_pkg;
  localparam int MAX_CAPACITY = 256;
  localparam int NUM_BUCKETS = 6;
  localparam int CAP_W = $clog2(MAX_CAPACITY + 1);
  localparam int SLOT_W = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int BKT_W = 3;
  localparam int ADDR_W = BKT_W + SLOT_W;
  localparam int DEPTH = NUM_BUCKETS * MAX_CAPACITY;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2 = 64'h94d049bb133111eb;
  localparam logic [31:0] SAT32 = 32'hffffffff;

  localparam logic [2:0] ACT_OWNER = 3'd3;
  localparam logic [0:0] FUNC_READ = 1'b1;
  localparam logic [0:0] REG_SEED = 1'b0;
  localparam logic [0:0] REG_CAP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_READ, ST_MIX1, ST_MUL1, ST_MIX2, ST_MUL2, ST_DIV, ST_PICK, ST_OUT
  } state_t;

  function automatic logic [63:0] gen_init(input logic [63:0] s, input int b);
    gen_init = s ^ (GOLDEN * 64'(b + 1));
  endfunction
endpackage

[sv/event_bucket_reservoir_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_bucket_reservoir_sampler
// per-bucket event counters with algorithm r reservoir sampling
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// in        in   in_valid / in_stall  func action side quantity read_bucket read_slot
// out       out  out_valid / out_stall bucket_valid .. seen_count
// cfg       in   apb write            seed (addr 0), sample_capacity (addr 8)
//
// a transaction passes eval and out (a read also read), a replacement adds mix,
// multiply, divide and pick states: 64-bit multiplies run as 32x32 partial
// products, the modulo in a restoring divider one quotient bit per cycle.
// reset is synchronous; counters and fills clear, sample memory is not cleared.
// in_stall is high from acceptance until the result transaction completes.
// ----------------------------------------------------------------------------
module event_bucket_reservoir_sampler import ebrs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [0:0]          func,
  input  logic [2:0]          action,
  input  logic [0:0]          side,
  input  logic signed [31:0]  quantity,
  input  logic [2:0]          read_bucket,
  input  logic [7:0]          read_slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [0:0]          bucket_valid,
  output logic [2:0]          bucket,
  output logic [31:0]         event_count,
  output logic [31:0]         owner_cancel_count,
  output logic [0:0]          sample_written,
  output logic [7:0]          sample_slot,
  output logic [30:0]         sample_value,
  output logic [8:0]          fill_level,
  output logic [31:0]         seen_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  state_t state, state_next;

  logic [63:0] seed;
  logic [8:0]  cap_reg;
  logic [63:0] rng [NUM_BUCKETS];
  logic [31:0] seen [NUM_BUCKETS];
  logic [CAP_W-1:0] fill [NUM_BUCKETS];
  logic [31:0] events [NUM_BUCKETS];
  logic [31:0] owners;
  logic [30:0] mem [DEPTH];
  logic [30:0] mem_q;

  // latched transaction
  logic        r_func;
  logic [2:0]  r_act;
  logic        r_side;
  logic [31:0] r_qty;
  logic [2:0]  r_rb;
  logic [7:0]  r_rs;
  logic [2:0]  b;

  // shared datapath: z register, partial product step, divider
  logic [63:0]  z;
  logic [63:0]  acc;
  logic [1:0]   pstep;
  logic [63:0]  rem;
  logic [63:0]  dividend;
  logic [6:0]   dcnt;
  logic [SLOT_W-1:0] w_slot;
  logic         do_write;
  logic [CAP_W-1:0] cap;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_CAP) ? {55'd0, cap_reg} : seed;

  assign cap = (cap_reg > 9'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : CAP_W'(cap_reg);
  assign in_stall = (state != ST_IDLE);
  assign b = r_func ? r_rb : 3'({r_act[1:0], 1'b0} | {2'd0, r_side});

  logic positive, mapped, rd_ok;
  assign positive = (r_qty != 32'd0) && !r_qty[31];
  assign mapped = r_func ? (r_rb < 3'(NUM_BUCKETS)) : (r_act <= 3'd2);
  assign rd_ok = (32'(r_rs) < 32'(fill[b])) && (32'(r_rs) < 32'(MAX_CAPACITY));

  // partial product operands
  logic [63:0] mul_k;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  assign mul_k = (state == ST_MUL1) ? MIX1 : MIX2;
  always_comb begin
    pa = pstep[0] ? z[63:32] : z[31:0];
    pb = pstep[1] ? mul_k[63:32] : mul_k[31:0];
  end
  assign pp = 64'(pa) * 64'(pb);

  // divider step
  logic [64:0] trial;
  logic [63:0] rsh;
  assign rsh = {rem[62:0], dividend[63]};
  assign trial = {1'b0, rsh} - {33'd0, seen[b]};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EVAL;
      ST_EVAL: begin
        if (r_func == FUNC_READ) state_next = ST_READ;
        else if (mapped && positive && cap != '0 && fill[b] >= cap) state_next = ST_MIX1;
        else state_next = ST_OUT;
      end
      ST_READ: state_next = ST_OUT;
      ST_MIX1: state_next = ST_MUL1;
      ST_MUL1: if (pstep == 2'd2) state_next = ST_MIX2;
      ST_MIX2: state_next = ST_MUL2;
      ST_MUL2: if (pstep == 2'd2) state_next = ST_DIV;
      ST_DIV:  if (dcnt == 7'd63) state_next = ST_PICK;
      ST_PICK: state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sample memory, written while the result is shown
  always_ff @(posedge clk) begin
    if (do_write && state == ST_OUT)
      mem[ADDR_W'({b, w_slot})] <= r_qty[30:0];
    mem_q <= mem[ADDR_W'({b, SLOT_W'(r_rs)})];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      cap_reg <= 9'd256;
      owners <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        rng[i] <= gen_init(64'd0, i);
        seen[i] <= '0;
        fill[i] <= '0;
        events[i] <= '0;
      end
      do_write <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[3] == REG_SEED) begin
          seed <= pwdata;
          for (int i = 0; i < NUM_BUCKETS; i++) rng[i] <= gen_init(pwdata, i);
        end else cap_reg <= pwdata[8:0];
      end
      case (state)
        ST_IDLE: begin
          do_write <= 1'b0;
          if (in_valid) begin
            r_func <= func; r_act <= action; r_side <= side;
            r_qty <= quantity; r_rb <= read_bucket; r_rs <= read_slot;
          end
        end
        ST_EVAL: if (r_func != FUNC_READ) begin
          if (r_act == ACT_OWNER) begin
            if (owners != SAT32) owners <= owners + 32'd1;
          end else if (mapped) begin
            if (events[b] != SAT32) events[b] <= events[b] + 32'd1;
            if (positive) begin
              if (seen[b] != SAT32) seen[b] <= seen[b] + 32'd1;
              if (cap != '0 && fill[b] < cap) begin
                w_slot <= SLOT_W'(fill[b]);
                do_write <= 1'b1;
                fill[b] <= fill[b] + CAP_W'(1);
              end else if (cap != '0) begin
                rng[b] <= rng[b] + GOLDEN;
                z <= rng[b] + GOLDEN;
              end
            end
          end
        end
        ST_MIX1: begin z <= z ^ (z >> 30); acc <= '0; pstep <= '0; end
        ST_MIX2: begin z <= z ^ (z >> 27); acc <= '0; pstep <= '0; end
        ST_MUL1, ST_MUL2: begin
          // low 64 bits: lo*lo + (hi*lo + lo*hi) << 32
          case (pstep)
            2'd0: acc <= pp;
            2'd1: acc <= acc + {pp[31:0], 32'd0};
            default: begin
              acc <= '0;
              z <= acc + {pp[31:0], 32'd0};
              if (state == ST_MUL2) begin
                dividend <= (acc + {pp[31:0], 32'd0}) ^ ((acc + {pp[31:0], 32'd0}) >> 31);
                rem <= '0;
                dcnt <= '0;
              end
            end
          endcase
          pstep <= pstep + 2'd1;
        end
        ST_DIV: begin
          rem <= trial[64] ? rsh : trial[63:0];
          dividend <= {dividend[62:0], 1'b0};
          dcnt <= dcnt + 7'd1;
        end
        ST_PICK: if (rem < 64'(cap)) begin
          w_slot <= SLOT_W'(rem);
          do_write <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result fields
  logic [SLOT_W-1:0] slot_out;
  assign slot_out = w_slot;
  always_comb begin
    owner_cancel_count = owners;
    bucket_valid = 1'(mapped);
    bucket = mapped ? b : 3'd0;
    event_count = mapped ? events[b] : 32'd0;
    fill_level = mapped ? 9'(fill[b]) : 9'd0;
    seen_count = mapped ? seen[b] : 32'd0;
    sample_written = 1'b0;
    sample_slot = '0;
    sample_value = '0;
    if (mapped && r_func == FUNC_READ) begin
      sample_slot = r_rs;
      sample_value = rd_ok ? mem_q : 31'd0;
    end else if (mapped && do_write) begin
      sample_written = 1'b1;
      sample_slot = 8'(slot_out);
      sample_value = r_qty[30:0];
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result shown while input open");
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_written && !r_func) |-> (32'(sample_slot) < 32'(MAX_CAPACITY)))
    else $error("slot beyond capacity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

[tb/tb_event_bucket_reservoir_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_bucket_reservoir_sampler
// self-checking bench: order events and sample reads against a local predictor
// ----------------------------------------------------------------------------
// a queued driver feeds the input channel with random gaps, a monitor compares
// every result transaction with the oldest prediction. the predictor mirrors
// the counters, fills, splitmix64 generators and the sample memory. several
// seed / capacity settings are applied over the apb port between phases.
// ----------------------------------------------------------------------------
module tb_event_bucket_reservoir_sampler;
  import ebrs_pkg::*;

  localparam logic [2:0] ACT_LIMIT = 3'd0;
  localparam logic [2:0] ACT_MARKET = 3'd1;
  localparam logic [2:0] ACT_CANCEL = 3'd2;
  localparam logic [2:0] ACT_OTHER = 3'd4;
  localparam logic [0:0] FUNC_OBSERVE = 1'b0;
  localparam logic [3:0] SEED_ADDR = 4'(8 * REG_SEED);
  localparam logic [3:0] CAP_ADDR = 4'(8 * REG_CAP);
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [0:0]  func;
    logic [2:0]  action;
    logic [0:0]  side;
    logic [31:0] quantity;
    logic [2:0]  read_bucket;
    logic [7:0]  read_slot;
  } order_item_t;

  typedef struct packed {
    logic [0:0]  bucket_valid;
    logic [2:0]  bucket;
    logic [31:0] event_count;
    logic [31:0] owner_cancel_count;
    logic [0:0]  sample_written;
    logic [7:0]  sample_slot;
    logic [30:0] sample_value;
    logic [8:0]  fill_level;
    logic [31:0] seen_count;
  } sample_result_t;

  logic clk, rst;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic [0:0] func = '0;
  logic [0:0] side = '0;
  logic [0:0] bucket_valid, sample_written;
  logic [2:0] action = '0;
  logic [2:0] read_bucket = '0;
  logic [2:0] bucket;
  logic signed [31:0] quantity = '0;
  logic [7:0] read_slot = '0;
  logic [7:0] sample_slot;
  logic [31:0] event_count, owner_cancel_count, seen_count;
  logic [30:0] sample_value;
  logic [8:0] fill_level;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;

  event_bucket_reservoir_sampler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .action(action), .side(side), .quantity(quantity),
    .read_bucket(read_bucket), .read_slot(read_slot),
    .out_valid(out_valid), .out_stall(out_stall),
    .bucket_valid(bucket_valid), .bucket(bucket), .event_count(event_count),
    .owner_cancel_count(owner_cancel_count), .sample_written(sample_written),
    .sample_slot(sample_slot), .sample_value(sample_value),
    .fill_level(fill_level), .seen_count(seen_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // mirror of the sampler state
  logic [63:0] seed_reg;
  logic [8:0]  cap_reg;
  logic [63:0] gen_state [NUM_BUCKETS];
  logic [31:0] seen_cnt [NUM_BUCKETS];
  logic [8:0]  fill_cnt [NUM_BUCKETS];
  logic [31:0] event_cnt [NUM_BUCKETS];
  logic [31:0] owner_cnt;
  logic [30:0] sample_mem [NUM_BUCKETS][MAX_CAPACITY];

  order_item_t    pending_items[$];
  sample_result_t expected_results[$];

  int errors = 0;
  int cycles = 0;
  int accepted_items = 0;
  int checked_results = 0;
  int replacements = 0;
  int item_wait = 0;
  int result_wait = 0;
  int long_hold = 0;
  logic hold_request = 0;
  logic burst_mode = 0;
  logic in_taken = 0;
  logic out_taken = 0;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

  function automatic void reload_generators();
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      gen_state[b] = seed_reg ^ (GOLDEN * 64'(b + 1));
    end
  endfunction

  // next splitmix64 draw of one bucket
  function automatic logic [63:0] next_draw(input int b);
    logic [63:0] z;
    gen_state[b] = gen_state[b] + GOLDEN;
    z = gen_state[b];
    z = (z ^ (z >> 30)) * MIX1;
    z = (z ^ (z >> 27)) * MIX2;
    return z ^ (z >> 31);
  endfunction

  // update the mirror for one accepted transaction and return its result
  function automatic sample_result_t predict_sample(input order_item_t it);
    sample_result_t r;
    int b;
    logic [8:0] cap_use;
    logic [63:0] pick;
    r = '0;
    b = -1;
    cap_use = (cap_reg > MAX_CAPACITY) ? 9'(MAX_CAPACITY) : cap_reg;
    if (it.func == FUNC_READ) begin
      if (it.read_bucket < NUM_BUCKETS) begin
        b = it.read_bucket;
        r.sample_slot = it.read_slot;
        if (it.read_slot < fill_cnt[b]) r.sample_value = sample_mem[b][it.read_slot];
      end
    end else if (it.action == ACT_OWNER) begin
      owner_cnt = sat_inc(owner_cnt);
    end else if (it.action <= ACT_CANCEL) begin
      b = it.action * 2 + it.side;
      event_cnt[b] = sat_inc(event_cnt[b]);
      // only strictly positive quantities are offered to the reservoir
      if (it.quantity != 0 && !it.quantity[31]) begin
        seen_cnt[b] = sat_inc(seen_cnt[b]);
        if (cap_use != 0) begin
          if (fill_cnt[b] < cap_use) begin
            r.sample_slot = fill_cnt[b][7:0];
            r.sample_written = 1'b1;
            fill_cnt[b] = fill_cnt[b] + 9'd1;
          end else begin
            replacements++;
            pick = next_draw(b) % {32'd0, seen_cnt[b]};
            if (pick < cap_use) begin
              r.sample_slot = pick[7:0];
              r.sample_written = 1'b1;
            end
          end
          if (r.sample_written) begin
            sample_mem[b][r.sample_slot] = it.quantity[30:0];
            r.sample_value = it.quantity[30:0];
          end
        end
      end
    end
    r.owner_cancel_count = owner_cnt;
    if (b >= 0) begin
      r.bucket_valid = 1'b1;
      r.bucket = 3'(b);
      r.event_count = event_cnt[b];
      r.fill_level = fill_cnt[b];
      r.seen_count = seen_cnt[b];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
             checked_results);
  endtask

  // clock and cycle watchdog
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // input side: predict at acceptance
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      expected_results = {expected_results,
                          predict_sample({func, action, side, quantity,
                                          read_bucket, read_slot})};
      accepted_items++;
    end
  end

  // driver: hold a stalled transaction, otherwise wait out a gap and send next
  always @(negedge clk) begin
    order_item_t it;
    if (!rst && !(in_valid && !in_taken)) begin
      if (in_valid) item_wait = (burst_mode || $urandom_range(0, 3) == 0) ? 0 :
                                $urandom_range(0, 13);
      if (item_wait > 0) begin
        item_wait--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        func <= it.func;
        action <= it.action;
        side <= it.side;
        quantity <= it.quantity;
        read_bucket <= it.read_bucket;
        read_slot <= it.read_slot;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    sample_result_t want;
    out_taken <= out_valid && !out_stall && !rst;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (bucket_valid !== want.bucket_valid)
          report_mismatch("bucket_valid", bucket_valid, want.bucket_valid);
        if (bucket !== want.bucket) report_mismatch("bucket", bucket, want.bucket);
        if (event_count !== want.event_count)
          report_mismatch("event_count", event_count, want.event_count);
        if (owner_cancel_count !== want.owner_cancel_count)
          report_mismatch("owner_cancel_count", owner_cancel_count,
                          want.owner_cancel_count);
        if (sample_written !== want.sample_written)
          report_mismatch("sample_written", sample_written, want.sample_written);
        if (sample_slot !== want.sample_slot)
          report_mismatch("sample_slot", sample_slot, want.sample_slot);
        if (sample_value !== want.sample_value)
          report_mismatch("sample_value", sample_value, want.sample_value);
        if (fill_level !== want.fill_level)
          report_mismatch("fill_level", fill_level, want.fill_level);
        if (seen_count !== want.seen_count)
          report_mismatch("seen_count", seen_count, want.seen_count);
      end
      checked_results++;
    end
  end

  // receiver stall: per-result random wait, plus one long hold on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      long_hold = 400;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else begin
      if (out_taken) result_wait = burst_mode ? 0 : $urandom_range(0, 13);
      if (result_wait > 0) begin
        result_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // wait until the block is idle with nothing outstanding
  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    drain();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == SEED_ADDR) begin
      seed_reg = data;
      reload_generators();
    end else begin
      cap_reg = data[8:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // keep the queue short so reads see an up to date fill
  task automatic send(input order_item_t it);
    while (pending_items.size() > 3) @(posedge clk);
    pending_items = {pending_items, it};
  endtask

  task automatic send_event(input logic [2:0] act, input logic [0:0] sd,
                            input logic [31:0] q);
    send('{FUNC_OBSERVE, act, sd, q, 3'($urandom), 8'($urandom)});
  endtask

  // read a slot that has been written, or a bucket past the last one
  task automatic send_read();
    int b;
    b = $urandom_range(0, 7);
    if (b < NUM_BUCKETS && fill_cnt[b] != 0)
      send('{FUNC_READ, 3'($urandom), 1'($urandom), $urandom, 3'(b),
             8'($urandom_range(0, fill_cnt[b] - 1))});
    else
      send('{FUNC_READ, 3'($urandom), 1'($urandom), $urandom,
             3'($urandom_range(NUM_BUCKETS, 7)), 8'($urandom)});
  endtask

  function automatic logic [31:0] random_quantity();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h8000_0000 | $urandom;
      2: return 32'h7fff_ffff;
      3: return 32'h0000_0001;
      default: return $urandom & 32'h7fff_ffff;
    endcase
  endfunction

  task automatic random_phase(input int count, input int bias_bucket);
    for (int i = 0; i < count; i++) begin
      if (i % 97 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2: send_read();
        3: send_event(ACT_OWNER, 1'($urandom), $urandom);
        4: send_event(3'($urandom_range(ACT_OTHER, 7)), 1'($urandom), $urandom);
        default: begin
          if (bias_bucket >= 0 && $urandom_range(0, 3) != 0)
            send_event(3'(bias_bucket / 2), 1'(bias_bucket % 2),
                       $urandom_range(1, 32'h7fff_ffff));
          else
            send_event(3'($urandom_range(ACT_LIMIT, ACT_CANCEL)), 1'($urandom),
                       random_quantity());
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    seed_reg = '0;
    cap_reg = 9'd256;
    reload_generators();
    owner_cnt = '0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      seen_cnt[b] = '0;
      fill_cnt[b] = '0;
      event_cnt[b] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: actions 0 to 3 on both sides, 4 to 7 once, quantity extremes, owner cancels
    send_event(ACT_LIMIT, 1'b0, 32'h7fff_ffff);
    send_event(ACT_LIMIT, 1'b1, 32'h0000_0001);
    send_event(ACT_MARKET, 1'b0, 32'h0000_0000);
    send_event(ACT_MARKET, 1'b1, 32'hffff_ffff);
    send_event(ACT_CANCEL, 1'b0, 32'h8000_0000);
    send_event(ACT_CANCEL, 1'b1, 32'h5555_5555);
    send_event(ACT_OWNER, 1'b0, 32'h2aaa_aaaa);
    send_event(ACT_OWNER, 1'b1, 32'h0000_0000);
    for (int a = ACT_OTHER; a <= 7; a++) send_event(3'(a), 1'($urandom), 32'd7);
    send_event(ACT_MARKET, 1'b0, 32'h0000_1234);
    send('{FUNC_READ, ACT_LIMIT, 1'b0, 32'd0, 3'd0, 8'd0});
    send('{FUNC_READ, ACT_OTHER, 1'b1, 32'd0, 3'd1, 8'd0});
    send('{FUNC_READ, ACT_LIMIT, 1'b0, 32'd0, 3'd6, 8'hff});
    send('{FUNC_READ, ACT_LIMIT, 1'b0, 32'd0, 3'd7, 8'h00});

    // capacity one: the second positive value in a bucket goes to a draw
    write_reg(CAP_ADDR, 64'd1);
    write_reg(SEED_ADDR, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 4; i++) send_event(ACT_LIMIT, 1'b0, 32'd100 + i);
    // capacity zero disables sampling
    write_reg(CAP_ADDR, 64'd0);
    send_event(ACT_CANCEL, 1'b1, 32'd9);
    send_event(ACT_MARKET, 1'b1, 32'd9);

    // random phases over several seed and capacity settings
    write_reg(SEED_ADDR, {$urandom, $urandom});
    write_reg(CAP_ADDR, 64'd4);
    random_phase(200, -1);

    // long receiver hold while the sender keeps offering transactions
    @(posedge clk);
    hold_request = 1'b1;
    random_phase(60, -1);

    write_reg(CAP_ADDR, 64'd511);
    write_reg(SEED_ADDR, 64'd0);
    // fill the limit buy reservoir to full capacity, then draw over it
    random_phase(380, 0);

    write_reg(CAP_ADDR, 64'd2);
    write_reg(SEED_ADDR, {$urandom, $urandom});
    random_phase(200, -1);

    write_reg(CAP_ADDR, 64'd0);
    random_phase(80, -1);

    write_reg(CAP_ADDR, 64'd256);
    write_reg(SEED_ADDR, {$urandom, $urandom});
    random_phase(240, 3);

    write_reg(CAP_ADDR, {55'd0, 9'($urandom_range(1, 300))});
    random_phase(200, -1);

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d transactions in, %0d results checked, %0d reservoir draws",
             accepted_items, checked_results, replacements);
    $display("capacity settings from 0 to 511, seeds incl. all zeros and ones");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end
endmodule

[event_bucket_reservoir_sampler.f]
sv/ebrs_pkg.sv
sv/event_bucket_reservoir_sampler.sv
tb/tb_event_bucket_reservoir_sampler.sv
